// ----- design/bt_pkg.sv -----
// Shared types, constants and tables for the beacon triangle pose block.
// No dependencies.
package bt_pkg;

   localparam int FRACTION_BITS = 16;
   localparam int ANGLE_STEPS   = 20;
   localparam int VEC_SHIFT     = 20;

   localparam logic [8:0]  CENTER_X_RESET = 9'd159;
   localparam logic [7:0]  CENTER_Y_RESET = 8'd99;
   localparam logic [21:0] REAL_EQUAL_RESET = 22'((64'd5 << FRACTION_BITS) >> 1);
   localparam logic [21:0] REAL_BASE_RESET  = 22'(64'd3 << FRACTION_BITS);

   localparam logic [1:0] CSR_CENTER_X   = 2'd0;
   localparam logic [1:0] CSR_CENTER_Y   = 2'd1;
   localparam logic [1:0] CSR_REAL_EQUAL = 2'd2;
   localparam logic [1:0] CSR_REAL_BASE  = 2'd3;

   localparam logic [1:0] APEX_BEACON0 = 2'd0;
   localparam logic [1:0] APEX_BEACON2 = 2'd1;
   localparam logic [1:0] APEX_BEACON1 = 2'd2;
   localparam logic [1:0] APEX_NONE    = 2'd3;

   localparam logic signed [34:0] OFF_MAX = 35'sd33554431;
   localparam logic signed [34:0] OFF_MIN = -35'sd33554432;
   localparam logic signed [15:0] ANGLE_LIMIT = 16'sd18000;

   typedef struct packed {
      logic [1:0]         status;
      logic [18:0]        side_a;
      logic [18:0]        side_b;
      logic [18:0]        side_base;
      logic signed [9:0]  rel_x;
      logic signed [8:0]  rel_y;
      logic signed [9:0]  head_x;
      logic signed [9:0]  head_y;
   } bt_item_type;

   // arctangent of 2^-i in 1/256 centidegree
   function automatic logic signed [24:0] atan_lookup(input logic [4:0] idx);
      logic signed [24:0] v;
      case (idx)
         5'd0:  v = 25'sd1152000;
         5'd1:  v = 25'sd680065;
         5'd2:  v = 25'sd359328;
         5'd3:  v = 25'sd182400;
         5'd4:  v = 25'sd91554;
         5'd5:  v = 25'sd45822;
         5'd6:  v = 25'sd22916;
         5'd7:  v = 25'sd11459;
         5'd8:  v = 25'sd5730;
         5'd9:  v = 25'sd2865;
         5'd10: v = 25'sd1432;
         5'd11: v = 25'sd716;
         5'd12: v = 25'sd358;
         5'd13: v = 25'sd179;
         5'd14: v = 25'sd90;
         5'd15: v = 25'sd45;
         5'd16: v = 25'sd22;
         5'd17: v = 25'sd11;
         5'd18: v = 25'sd6;
         5'd19: v = 25'sd3;
         default: v = 25'sd0;
      endcase
      return v;
   endfunction

endpackage

// ----- design/bt_front.sv -----
// Front end: squared sides, centroid, centre offset and apex selection.
// Depends on bt_pkg.
module bt_front (
   input  logic [50:0]         frame,
   input  logic [8:0]          center_x,
   input  logic [7:0]          center_y,
   output bt_pkg::bt_item_type item
);
   import bt_pkg::*;

   logic [8:0]  b0x, b1x, b2x;
   logic [7:0]  b0y, b1y, b2y;
   logic [18:0] s01, s02, s12;
   logic [10:0] sum_x;
   logic [9:0]  sum_y;
   logic [19:0] prod_x, prod_y;
   logic [8:0]  cx;
   logic [7:0]  cy;
   logic [8:0]  apex_x;
   logic [7:0]  apex_y;

   function automatic logic [18:0] sq_dist(input logic [8:0] ax, input logic [8:0] ay,
                                           input logic [8:0] bx, input logic [8:0] by);
      logic signed [9:0]  dx, dy;
      logic signed [19:0] px, py;
      dx = $signed({1'b0, ax}) - $signed({1'b0, bx});
      dy = $signed({1'b0, ay}) - $signed({1'b0, by});
      px = dx * dx;
      py = dy * dy;
      return 19'(px + py);
   endfunction

   assign b0x = frame[8:0];
   assign b0y = frame[16:9];
   assign b1x = frame[25:17];
   assign b1y = frame[33:26];
   assign b2x = frame[42:34];
   assign b2y = frame[50:43];

   assign s01 = sq_dist(b0x, {1'b0, b0y}, b1x, {1'b0, b1y});
   assign s02 = sq_dist(b0x, {1'b0, b0y}, b2x, {1'b0, b2y});
   assign s12 = sq_dist(b1x, {1'b0, b1y}, b2x, {1'b0, b2y});

   // divide by 3 as multiply by 683 / 2048, exact over the sum range
   assign sum_x  = 11'(b0x) + 11'(b1x) + 11'(b2x);
   assign sum_y  = 10'(b0y) + 10'(b1y) + 10'(b2y);
   assign prod_x = 20'(sum_x * 10'd683);
   assign prod_y = 20'(sum_y * 10'd683);
   assign cx     = prod_x[19:11];
   assign cy     = prod_y[18:11];

   always_comb begin
      item.side_a    = s01;
      item.side_b    = s02;
      item.side_base = s12;
      apex_x         = b0x;
      apex_y         = b0y;
      if (s01 == s02) begin
         item.status = APEX_BEACON0;
      end else if (s02 == s12) begin
         item.status    = APEX_BEACON2;
         item.side_a    = s12;
         item.side_base = s01;
         apex_x         = b2x;
         apex_y         = b2y;
      end else if (s01 == s12) begin
         item.status    = APEX_BEACON1;
         item.side_b    = s12;
         item.side_base = s02;
         apex_x         = b1x;
         apex_y         = b1y;
      end else begin
         item.status = APEX_NONE;
      end
      item.rel_x  = $signed({1'b0, cx}) - $signed({1'b0, center_x});
      item.rel_y  = $signed({1'b0, cy}) - $signed({1'b0, center_y});
      item.head_x = $signed({1'b0, apex_x}) - $signed({1'b0, cx});
      item.head_y = $signed({2'b0, apex_y}) - $signed({2'b0, cy});
   end

endmodule

// ----- design/bt_fifo.sv -----
// Two-entry queue between front end and back end.
// Depends on bt_pkg.
module bt_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bt_pkg::bt_item_type push_item,
   input  logic                pop,
   output bt_pkg::bt_item_type pop_item,
   output logic                full,
   output logic                empty
);
   import bt_pkg::*;

   bt_item_type entry_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   assign pop_item = entry_ff[rd_ptr_ff];
   assign full     = count_ff == 2'd2;
   assign empty    = count_ff == 2'd0;

endmodule

// ----- design/bt_back.sv -----
// Back end: square roots, ratio divisions, CORDIC heading, offset scaling, result register.
// Depends on bt_pkg.
module bt_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_ready,
   input  bt_pkg::bt_item_type item,
   output logic                item_pop,
   input  logic [21:0]         real_equal_side,
   input  logic [21:0]         real_base_side,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [70:0]         rsp_data
);
   import bt_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_SQRT, S_DIV, S_CPREP, S_CORDIC, S_MUL_X, S_MUL_Y, S_OUT
   } state_type;

   state_type          state_ff, state_in;
   bt_item_type        item_ff, item_in;
   logic [1:0]         sel_ff, sel_in;
   logic [4:0]         step_ff, step_in;
   logic [19:0]        sq_val_ff, sq_val_in, sq_root_ff, sq_root_in, sq_bit_ff, sq_bit_in;
   logic [9:0]         root_ff [3];
   logic [9:0]         root_in [3];
   logic [23:0]        quo_ff, quo_in, sum_ff, sum_in;
   logic [9:0]         rem_ff, rem_in;
   logic signed [33:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [24:0] cz_ff, cz_in;
   logic               zero_side_ff, zero_side_in, zero_head_ff, zero_head_in;
   logic signed [9:0]  held_hx_ff, held_hx_in, held_hy_ff, held_hy_in;
   logic [23:0]        held_ratio_ff, held_ratio_in;
   logic signed [25:0] off_x_ff, off_x_in, off_y_ff, off_y_in;
   logic signed [15:0] heading_ff, heading_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [70:0]        rsp_data_ff, rsp_data_in;

   logic [19:0]        sq_trial;
   logic [10:0]        div_trial;
   logic [9:0]         divisor;
   logic signed [33:0] xs, ys, xa, ya;
   logic signed [24:0] z_trunc;
   logic signed [34:0] product;
   logic signed [9:0]  rel_sel;
   logic signed [25:0] sat_val;

   always_comb begin
      case (sel_ff)
         2'd0:    divisor = root_ff[0];
         2'd1:    divisor = root_ff[1];
         2'd2:    divisor = root_ff[2];
         default: divisor = 10'd3;
      endcase
   end

   assign sq_trial  = sq_root_ff + sq_bit_ff;
   assign div_trial = {rem_ff, quo_ff[23]};
   assign xs        = cx_ff >>> step_ff;
   assign ys        = cy_ff >>> step_ff;
   assign xa        = -(34'(held_hx_ff) <<< VEC_SHIFT);
   assign ya        = 34'(held_hy_ff) <<< VEC_SHIFT;
   assign z_trunc   = (cz_ff < 0) ? ((cz_ff + 25'sd255) >>> 8) : (cz_ff >>> 8);
   assign rel_sel   = (state_ff == S_MUL_X) ? item_ff.rel_x : 10'(item_ff.rel_y);
   assign product   = rel_sel * $signed({1'b0, held_ratio_ff});
   assign sat_val   = (product > OFF_MAX) ? OFF_MAX[25:0] :
                      (product < OFF_MIN) ? OFF_MIN[25:0] : product[25:0];

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      sel_in        = sel_ff;
      step_in       = step_ff;
      sq_val_in     = sq_val_ff;
      sq_root_in    = sq_root_ff;
      sq_bit_in     = sq_bit_ff;
      root_in       = root_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      sum_in        = sum_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      cz_in         = cz_ff;
      zero_side_in  = zero_side_ff;
      zero_head_in  = zero_head_ff;
      held_hx_in    = held_hx_ff;
      held_hy_in    = held_hy_ff;
      held_ratio_in = held_ratio_ff;
      off_x_in      = off_x_ff;
      off_y_in      = off_y_ff;
      heading_in    = heading_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      item_pop      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (item_ready) begin
               item_pop     = 1'b1;
               item_in      = item;
               sel_in       = 2'd0;
               sq_val_in    = 20'(item.side_a);
               sq_root_in   = '0;
               sq_bit_in    = 20'd1 << 18;
               zero_side_in = 1'b0;
               state_in     = S_SQRT;
            end
         end
         S_SQRT: begin
            if (sq_val_ff >= sq_trial) begin
               sq_val_in  = sq_val_ff - sq_trial;
               sq_root_in = (sq_root_ff >> 1) + sq_bit_ff;
            end else begin
               sq_root_in = sq_root_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
            if (sq_bit_ff == 20'd1) begin
               root_in[sel_ff] = sq_root_in[9:0];
               sq_root_in      = '0;
               sq_bit_in       = 20'd1 << 18;
               sq_val_in       = (sel_ff == 2'd0) ? 20'(item_ff.side_b) : 20'(item_ff.side_base);
               sel_in          = sel_ff + 2'd1;
               if (sel_ff == 2'd2) begin
                  sel_in = 2'd0;
                  if (item_ff.status == APEX_NONE) begin
                     state_in = S_CPREP;
                  end else if (root_ff[0] == '0 || root_ff[1] == '0 || root_in[2] == '0) begin
                     zero_side_in = 1'b1;
                     state_in     = S_CPREP;
                  end else begin
                     quo_in   = 24'(real_equal_side);
                     rem_in   = '0;
                     step_in  = '0;
                     sum_in   = '0;
                     state_in = S_DIV;
                  end
               end
            end
         end
         S_DIV: begin
            if (div_trial >= 11'(divisor)) begin
               rem_in = 10'(div_trial - 11'(divisor));
               quo_in = {quo_ff[22:0], 1'b1};
            end else begin
               rem_in = div_trial[9:0];
               quo_in = {quo_ff[22:0], 1'b0};
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd23) begin
               step_in = '0;
               rem_in  = '0;
               sel_in  = sel_ff + 2'd1;
               if (sel_ff == 2'd3) begin
                  held_ratio_in = quo_in;
                  held_hx_in    = item_ff.head_x;
                  held_hy_in    = item_ff.head_y;
                  state_in      = S_CPREP;
               end else begin
                  sum_in = sum_ff + quo_in;
                  case (sel_ff)
                     2'd0:    quo_in = 24'(real_equal_side);
                     2'd1:    quo_in = 24'(real_base_side);
                     default: quo_in = sum_in;
                  endcase
               end
            end
         end
         S_CPREP: begin
            zero_head_in = held_hx_ff == '0 && held_hy_ff == '0;
            step_in      = '0;
            cx_in        = ya;
            cy_in        = xa;
            cz_in        = '0;
            if (ya < 0) begin
               if (xa >= 0) begin
                  cx_in = xa;
                  cy_in = -ya;
                  cz_in = 25'sd2 * atan_lookup(5'd0);
               end else begin
                  cx_in = -xa;
                  cy_in = ya;
                  cz_in = -(25'sd2 * atan_lookup(5'd0));
               end
            end
            state_in = S_CORDIC;
         end
         S_CORDIC: begin
            if (cy_ff > 0) begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               cz_in = cz_ff + atan_lookup(step_ff);
            end else begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               cz_in = cz_ff - atan_lookup(step_ff);
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(ANGLE_STEPS - 1)) begin
               step_in  = '0;
               state_in = S_MUL_X;
            end
         end
         S_MUL_X: begin
            off_x_in = sat_val;
            if (zero_head_ff) begin
               heading_in = '0;
            end else if (z_trunc > 25'(ANGLE_LIMIT)) begin
               heading_in = ANGLE_LIMIT;
            end else if (z_trunc < -25'(ANGLE_LIMIT)) begin
               heading_in = -ANGLE_LIMIT;
            end else begin
               heading_in = z_trunc[15:0];
            end
            state_in = S_MUL_Y;
         end
         S_MUL_Y: begin
            off_y_in = sat_val;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {zero_side_ff | zero_head_ff, item_ff.status, heading_ff,
                               off_y_ff, off_x_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      sel_ff       <= sel_in;
      step_ff      <= step_in;
      sq_val_ff    <= sq_val_in;
      sq_root_ff   <= sq_root_in;
      sq_bit_ff    <= sq_bit_in;
      root_ff      <= root_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      sum_ff       <= sum_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      cz_ff        <= cz_in;
      zero_side_ff <= zero_side_in;
      zero_head_ff <= zero_head_in;
      off_x_ff     <= off_x_in;
      off_y_ff     <= off_y_in;
      heading_ff   <= heading_in;
      rsp_data_ff  <= rsp_data_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         held_hx_ff    <= '0;
         held_hy_ff    <= '0;
         held_ratio_ff <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         held_hx_ff    <= held_hx_in;
         held_hy_ff    <= held_hy_in;
         held_ratio_ff <= held_ratio_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($signed(rsp_data_ff[67:52]) <= ANGLE_LIMIT &&
                        $signed(rsp_data_ff[67:52]) >= -ANGLE_LIMIT))
      else $error("heading out of range");

   a_cordic_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CORDIC |-> step_ff < 5'(ANGLE_STEPS))
      else $error("cordic step overrun");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      item_pop |=> state_ff == S_SQRT && sel_ff == 2'd0)
      else $error("pop did not start root pass");

   a_no_update_none: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> item_ff.status != APEX_NONE && !zero_side_ff)
      else $error("ratio division on a frame without apex");

endmodule

// ----- design/beacon_triangle_pose.sv -----
// Top level of the beacon triangle pose block: configuration registers and stream ports.
// Depends on bt_pkg, bt_front, bt_fifo, bt_back.
//
// Each frame transfer yields one result transfer. A frame is classified in the cycle it is
// taken and waits in a two-entry queue; the back end then works on one frame at a time:
// it takes the frame, computes three bit-serial square roots, then four bit-serial divisions
// when a ratio is updated, a CORDIC setup step, the CORDIC heading iterations, the two
// offset multiplies and the load of the result register, plus any receiver stall.
// Up to two frames are taken ahead.
module beacon_triangle_pose (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // beacon0_x, beacon0_y, beacon1_x, beacon1_y, beacon2_x, beacon2_y, zero pad
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // offset_x_m, offset_y_m, heading_centideg, apex_status, degenerate, zero pad
   output logic [71:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [21:0] csr_wdata
);
   import bt_pkg::*;

   logic [8:0]  center_x_ff;
   logic [7:0]  center_y_ff;
   logic [21:0] real_equal_ff, real_base_ff;
   bt_item_type front_item, queue_item;
   logic        q_full, q_empty, q_pop;
   logic [70:0] rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff   <= CENTER_X_RESET;
         center_y_ff   <= CENTER_Y_RESET;
         real_equal_ff <= REAL_EQUAL_RESET;
         real_base_ff  <= REAL_BASE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CENTER_X:   center_x_ff   <= csr_wdata[8:0];
            CSR_CENTER_Y:   center_y_ff   <= csr_wdata[7:0];
            CSR_REAL_EQUAL: real_equal_ff <= csr_wdata;
            CSR_REAL_BASE:  real_base_ff  <= csr_wdata;
            default:        ;
         endcase
      end
   end

   bt_front u_front (
      .frame    (req_tdata[50:0]),
      .center_x (center_x_ff),
      .center_y (center_y_ff),
      .item     (front_item)
   );

   bt_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid && req_tready),
      .push_item (front_item),
      .pop       (q_pop),
      .pop_item  (queue_item),
      .full      (q_full),
      .empty     (q_empty)
   );

   bt_back u_back (
      .clock           (clock),
      .reset           (reset),
      .item_ready      (!q_empty),
      .item            (queue_item),
      .item_pop        (q_pop),
      .real_equal_side (real_equal_ff),
      .real_base_side  (real_base_ff),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_data        (rsp_data)
   );

   assign req_tready = !q_full;
   assign rsp_tdata  = {1'b0, rsp_data};

endmodule

// ----- verif/beacon_triangle_pose_tb.sv -----
`timescale 1ns / 100ps
// Testbench for beacon_triangle_pose: frames of three beacon positions in, pose out.
// Depends on bt_pkg and the block's RTL; a scoreboard class predicts and checks results.

class pose_scoreboard;
   bit [8:0]  center_x;
   bit [7:0]  center_y;
   bit [21:0] real_equal;
   bit [21:0] real_base;
   int        head_x;
   int        head_y;
   bit [23:0] ratio;
   bit [71:0] pending_q[$];
   int        errors;
   int        checked;

   function void init();
      center_x   = bt_pkg::CENTER_X_RESET;
      center_y   = bt_pkg::CENTER_Y_RESET;
      real_equal = bt_pkg::REAL_EQUAL_RESET;
      real_base  = bt_pkg::REAL_BASE_RESET;
      head_x = 0;
      head_y = 0;
      ratio  = 0;
      errors = 0;
      checked = 0;
   endfunction

   function void write_reg(bit [1:0] idx, bit [21:0] v);
      case (idx)
         bt_pkg::CSR_CENTER_X:   center_x = v[8:0];
         bt_pkg::CSR_CENTER_Y:   center_y = v[7:0];
         bt_pkg::CSR_REAL_EQUAL: real_equal = v;
         default:                real_base = v;
      endcase
   endfunction

   function int unsigned int_sqrt(int unsigned v);
      int unsigned r;
      r = 0;
      while ((r + 1) * (r + 1) <= v) r++;
      return r;
   endfunction

   function longint shift_floor(longint v, int s);
      return v >>> s;
   endfunction

   function int heading_cd(int a, int b);
      longint x, y, z, t, xs, ys, r;
      x = longint'(b) * (longint'(1) << 20);
      y = longint'(a) * (longint'(1) << 20);
      z = 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = 2 * bt_pkg::atan_lookup(0);
         end else begin
            t = x; x = -y; y = t; z = -2 * bt_pkg::atan_lookup(0);
         end
      end
      for (int i = 0; i < 20; i++) begin
         xs = shift_floor(x, i);
         ys = shift_floor(y, i);
         if (y > 0) begin
            x += ys; y -= xs; z += bt_pkg::atan_lookup(i[4:0]);
         end else begin
            x -= ys; y += xs; z -= bt_pkg::atan_lookup(i[4:0]);
         end
      end
      r = z / 256;
      if (r > 18000) r = 18000;
      if (r < -18000) r = -18000;
      return int'(r);
   endfunction

   function longint clamp_offset(longint v);
      if (v > 33554431) return 33554431;
      if (v < -33554432) return -33554432;
      return v;
   endfunction

   function void note_frame(bit [55:0] d);
      int bx[3], by[3];
      int s01, s02, s12, cx, cy, rx, ry, k, hd;
      int unsigned sa, sb, sc, da, db, dc;
      longint sum;
      bit [1:0] status;
      bit degen;
      bit [25:0] ox, oy;
      bit [15:0] hc;
      bit [71:0] entry;
      for (int i = 0; i < 3; i++) begin
         bx[i] = d[17 * i +: 9];
         by[i] = d[17 * i + 9 +: 8];
      end
      s01 = (bx[0] - bx[1]) ** 2 + (by[0] - by[1]) ** 2;
      s02 = (bx[0] - bx[2]) ** 2 + (by[0] - by[2]) ** 2;
      s12 = (bx[1] - bx[2]) ** 2 + (by[1] - by[2]) ** 2;
      cx = (bx[0] + bx[1] + bx[2]) / 3;
      cy = (by[0] + by[1] + by[2]) / 3;
      rx = cx - int'(center_x);
      ry = cy - int'(center_y);
      degen = 0;
      k = 0; sa = 0; sb = 0; sc = 0;
      if (s01 == s02) begin
         status = bt_pkg::APEX_BEACON0; k = 0; sa = s01; sb = s02; sc = s12;
      end else if (s02 == s12) begin
         status = bt_pkg::APEX_BEACON2; k = 2; sa = s12; sb = s02; sc = s01;
      end else if (s01 == s12) begin
         status = bt_pkg::APEX_BEACON1; k = 1; sa = s01; sb = s12; sc = s02;
      end else begin
         status = bt_pkg::APEX_NONE;
      end
      if (status != bt_pkg::APEX_NONE) begin
         da = int_sqrt(sa); db = int_sqrt(sb); dc = int_sqrt(sc);
         if (da == 0 || db == 0 || dc == 0) begin
            degen = 1;
         end else begin
            sum = real_equal / da + real_equal / db + real_base / dc;
            ratio = 24'(sum / 3);
            head_x = bx[k] - cx;
            head_y = by[k] - cy;
         end
      end
      if (head_x == 0 && head_y == 0) begin
         hd = 0;
         degen = 1;
      end else begin
         hd = heading_cd(-head_x, head_y);
      end
      ox = 26'(clamp_offset(longint'(rx) * longint'(ratio)));
      oy = 26'(clamp_offset(longint'(ry) * longint'(ratio)));
      hc = 16'(hd);
      entry = {1'b0, degen, status, hc, oy, ox};
      pending_q.insert(pending_q.size(), entry);
   endfunction

   function void report_mismatch(string what, longint exp, longint got);
      errors++;
      if (errors <= 30)
         $display("MISMATCH result %0d %s: expected %0h got %0h", checked, what, exp, got);
   endfunction

   function void check_result(bit [71:0] got);
      bit [71:0] exp;
      checked++;
      if (pending_q.size() == 0) begin
         report_mismatch("result with nothing expected", 0, longint'(got[63:0]));
         return;
      end
      exp = pending_q.pop_front();
      if (got[25:0] != exp[25:0])
         report_mismatch("offset_x_m", longint'(exp[25:0]), longint'(got[25:0]));
      if (got[51:26] != exp[51:26])
         report_mismatch("offset_y_m", longint'(exp[51:26]), longint'(got[51:26]));
      if (got[67:52] != exp[67:52])
         report_mismatch("heading_centideg", longint'(exp[67:52]), longint'(got[67:52]));
      if (got[69:68] != exp[69:68])
         report_mismatch("apex_status", longint'(exp[69:68]), longint'(got[69:68]));
      if (got[70] != exp[70])
         report_mismatch("degenerate", longint'(exp[70]), longint'(got[70]));
      if (got[71] != 1'b0) report_mismatch("pad", 0, longint'(got[71]));
   endfunction
endclass

module beacon_triangle_pose_tb;
   import bt_pkg::*;

   localparam int STALL_LIMIT = 20000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [21:0] csr_wdata;

   pose_scoreboard pose_sb;
   int  send_idle_pct;
   int  recv_stall_pct;
   int  idle_count;
   int  frames_sent;
   bit  timed_out;

   beacon_triangle_pose u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // receiver side with random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) pose_sb.check_result(rsp_tdata);
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog on cycles with no transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_count <= 0;
      end else begin
         idle_count <= idle_count + 1;
         if (idle_count >= STALL_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("watchdog expired");
            $display("simulation failed");
            $finish;
         end
      end
   end

   function automatic logic [55:0] pack_frame(int x0, int y0, int x1, int y1, int x2, int y2);
      return {5'd0, 8'(y2), 9'(x2), 8'(y1), 9'(x1), 8'(y0), 9'(x0)};
   endfunction

   // valid stays high into the next frame; drain() drops it
   task automatic send_frame(logic [55:0] d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pose_sb.note_frame(d);
      frames_sent++;
   endtask

   task automatic write_csr(logic [1:0] idx, logic [21:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      pose_sb.write_reg(idx, v);
      @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pose_sb.pending_q.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   // isosceles frame with random apex position in the list, random orientation and size
   function automatic logic [55:0] make_isosceles();
      int ax, ay, dx, dy, px, py, qx, qy, slot;
      int p[3][2];
      do begin
         ax = $urandom_range(319); ay = $urandom_range(199);
         dx = $urandom_range(60) - 30; dy = $urandom_range(60) - 30;
         case ($urandom_range(2))
            0: begin px = ax + dx; py = ay + dy; qx = ax - dx; qy = ay + dy; end
            1: begin px = ax + dx; py = ay + dy; qx = ax + dx; qy = ay - dy; end
            default: begin px = ax + dx; py = ay + dy; qx = ax - dy; qy = ay + dx; end
         endcase
      end while (px < 0 || px > 319 || qx < 0 || qx > 319 ||
                 py < 0 || py > 199 || qy < 0 || qy > 199);
      slot = $urandom_range(2);
      p[slot][0] = ax; p[slot][1] = ay;
      p[(slot + 1) % 3][0] = px; p[(slot + 1) % 3][1] = py;
      p[(slot + 2) % 3][0] = qx; p[(slot + 2) % 3][1] = qy;
      return pack_frame(p[0][0], p[0][1], p[1][0], p[1][1], p[2][0], p[2][1]);
   endfunction

   function automatic logic [55:0] make_any();
      return pack_frame($urandom_range(319), $urandom_range(199), $urandom_range(319),
                        $urandom_range(199), $urandom_range(319), $urandom_range(199));
   endfunction

   task automatic run_random(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 75) send_frame(make_isosceles());
         else send_frame(make_any());
      end
   endtask

   initial begin
      pose_sb = new();
      pose_sb.init();
      timed_out   = 1'b0;
      frames_sent = 0;
      idle_count  = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_index  <= CSR_CENTER_X;
      csr_wdata  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero heading, coincident points, each apex slot, extremes
      send_frame(pack_frame(10, 10, 10, 10, 10, 10));
      send_frame(pack_frame(0, 0, 319, 199, 0, 199));
      send_frame(pack_frame(160, 50, 140, 90, 180, 90));
      send_frame(pack_frame(140, 90, 180, 90, 160, 50));
      send_frame(pack_frame(140, 90, 160, 50, 180, 90));
      send_frame(pack_frame(160, 150, 140, 100, 180, 100));
      send_frame(pack_frame(100, 100, 120, 100, 100, 100));
      send_frame(pack_frame(100, 100, 100, 100, 130, 140));
      send_frame(pack_frame(50, 100, 90, 80, 90, 120));
      send_frame(pack_frame(250, 100, 210, 80, 210, 120));
      send_frame(pack_frame(319, 199, 318, 198, 318, 199));
      send_frame(pack_frame(0, 0, 1, 1, 1, 0));
      send_frame(pack_frame(319, 0, 0, 199, 319, 199));
      send_frame(pack_frame(511, 255, 0, 0, 0, 0));
      send_frame(pack_frame(1, 0, 0, 1, 0, 0));
      drain();

      write_csr(CSR_CENTER_X, 22'd0);
      write_csr(CSR_CENTER_Y, 22'd0);
      write_csr(CSR_REAL_EQUAL, 22'h3FFFFF);
      write_csr(CSR_REAL_BASE, 22'h3FFFFF);
      send_frame(pack_frame(319, 199, 318, 198, 318, 199));
      send_frame(pack_frame(0, 0, 1, 1, 1, 0));
      run_random(150);
      drain();

      send_idle_pct = 88;
      write_csr(CSR_CENTER_X, 22'd319);
      write_csr(CSR_CENTER_Y, 22'd199);
      write_csr(CSR_REAL_EQUAL, 22'd0);
      write_csr(CSR_REAL_BASE, 22'd1);
      run_random(150);
      drain();

      send_idle_pct  = 0;
      recv_stall_pct = 88;
      write_csr(CSR_CENTER_X, 22'($urandom_range(319)));
      write_csr(CSR_CENTER_Y, 22'($urandom_range(199)));
      write_csr(CSR_REAL_EQUAL, 22'($urandom));
      write_csr(CSR_REAL_BASE, 22'($urandom));
      run_random(150);
      drain();

      send_idle_pct  = 18;
      recv_stall_pct = 18;
      write_csr(CSR_CENTER_X, 22'(CENTER_X_RESET));
      write_csr(CSR_CENTER_Y, 22'(CENTER_Y_RESET));
      write_csr(CSR_REAL_EQUAL, 22'(REAL_EQUAL_RESET));
      write_csr(CSR_REAL_BASE, 22'(REAL_BASE_RESET));
      run_random(180);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_random(150);
      drain();

      $display("frames sent %0d, results checked %0d, across five register settings",
               frames_sent, pose_sb.checked);
      $display("idle and stall mixes: none, sender, receiver, both");
      if (pose_sb.errors == 0 && pose_sb.pending_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
